// ===== hdl/cma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants of the centered moving average unit.
// ----------------------------------------------------------------------------
package cma_pkg;

    localparam int SAMPLE_BITS      = 16;
    localparam int MAX_HALF_WIDTH   = 15;
    localparam int HALF_WIDTH_BITS  = 4;
    localparam int HALF_WIDTH_RESET = 1;
    localparam int FRAC_BITS        = 8;
    localparam int AVG_BITS         = 24;
    localparam int AVG_MAX          = (1 << (AVG_BITS - 1)) - 1;
    // magnitude of the most negative average
    localparam int AVG_MIN_MAG      = 1 << (AVG_BITS - 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          is_last;
    } in_item_t;

    typedef struct packed {
        logic signed [AVG_BITS-1:0] average;
        logic                       final_result;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic rd_issue;
        logic remove;
        logic div_start;
        logic load_out;
        logic j_dec;
        logic end_item;
    } cma_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic c_gt_j;
        logic w_gt_target;
        logic j_zero;
        logic last;
        logic div_done;
    } cma_status_t;

endpackage

// ===== hdl/centered_moving_average_unit.sv =====
`timescale 1ns / 1ps
// a result follows its sample, one window trim and the 30 divider steps
// early in a sequence, before the window is full, no trim is needed
// a new sample waits until the results of the last one are out; a last sample adds extra results
// the bit-serial divider yields one quotient bit per cycle; output stalls hold the flow
// reset: asynchronous, active low; half width returns to 1, window and counters to zero
// sample store contents are undefined after reset and are written before they are read
// ----------------------------------------------------------------------------
// centered_moving_average_unit
// Centered moving average over a flagged sample sequence, window clipped at
// both ends, mean in signed fixed point with 8 fraction bits.
// ----------------------------------------------------------------------------
module centered_moving_average_unit #(
    parameter int MAX_HALF_WIDTH = cma_pkg::MAX_HALF_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cma_pkg::HALF_WIDTH_BITS-1:0] cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  cma_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output cma_pkg::out_item_t                  out_data
);

    cma_pkg::cma_cmd_t    cmd;
    cma_pkg::cma_status_t status;

    cma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    cma_datapath #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

// ===== hdl/cma_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_div
// Bit-serial restoring divider: window sum * 256 / count, truncated toward
// zero and saturated to the average range. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module cma_div #(
    parameter int SUM_BITS = 22,
    parameter int CNT_BITS = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic signed [SUM_BITS-1:0]       sum,
    input  logic [CNT_BITS-1:0]              divisor,
    output logic                             done,
    output logic signed [cma_pkg::AVG_BITS-1:0] quotient
);

    localparam int QW       = SUM_BITS + cma_pkg::FRAC_BITS;
    localparam int STEP_BITS = $clog2(QW);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic                  neg_reg, neg_next;
    logic [QW-1:0]         q_reg, q_next;
    logic [CNT_BITS-1:0]   rem_reg, rem_next;
    logic [CNT_BITS-1:0]   d_reg, d_next;

    logic [SUM_BITS-1:0]   mag;
    logic [CNT_BITS:0]     rem_sh;
    logic [CNT_BITS:0]     rem_sub;
    logic                  ge;
    logic [cma_pkg::AVG_BITS-1:0] avg_mag;

    assign mag     = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
    assign rem_sh  = {rem_reg, q_reg[QW-1]};
    assign ge      = rem_sh >= {1'b0, d_reg};
    assign rem_sub = rem_sh - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = sum[SUM_BITS-1];
            q_next    = {mag, {cma_pkg::FRAC_BITS{1'b0}}};
            rem_next  = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[QW-2:0], ge};
            rem_next = ge ? rem_sub[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
            if (step_reg == STEP_BITS'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign avg_mag = q_reg[cma_pkg::AVG_BITS-1:0];

    // saturate, then restore the sign
    always_comb
    begin
        priority if (!neg_reg && q_reg > QW'(cma_pkg::AVG_MAX))
            quotient = cma_pkg::AVG_BITS'(cma_pkg::AVG_MAX);
        else if (neg_reg && q_reg > QW'(cma_pkg::AVG_MIN_MAG))
            quotient = cma_pkg::AVG_BITS'(cma_pkg::AVG_MIN_MAG);
        else if (neg_reg)
            quotient = -avg_mag;
        else
            quotient = avg_mag;
    end

    assign done = done_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a preceding busy cycle");

endmodule

// ===== hdl/cma_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_datapath
// Sample ring store, running window sum, sequence counters, half width
// register and the output register.
// ----------------------------------------------------------------------------
module cma_datapath #(
    parameter int MAX_HALF_WIDTH = cma_pkg::MAX_HALF_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cma_pkg::HALF_WIDTH_BITS-1:0] cfg_wdata,
    input  cma_pkg::in_item_t                   in_data,
    input  cma_pkg::cma_cmd_t                   cmd,
    output cma_pkg::cma_status_t                status,
    output cma_pkg::out_item_t                  out_data
);

    localparam int STORE_SLOTS = 2 * MAX_HALF_WIDTH + 2;
    localparam int ADDR_BITS   = $clog2(STORE_SLOTS);
    localparam int CNT_BITS    = $clog2(STORE_SLOTS + 1);
    localparam int SUM_BITS    = cma_pkg::SAMPLE_BITS + CNT_BITS;

    logic signed [cma_pkg::SAMPLE_BITS-1:0] store_mem [STORE_SLOTS];
    logic signed [cma_pkg::SAMPLE_BITS-1:0] rdata_reg;

    logic [cma_pkg::HALF_WIDTH_BITS-1:0] hw_reg, hw_next;
    logic signed [SUM_BITS-1:0]          sum_reg, sum_next;
    logic [CNT_BITS-1:0]                 seen_reg, seen_next;
    logic [CNT_BITS-1:0]                 win_reg, win_next;
    logic [ADDR_BITS-1:0]                ws_reg, ws_next;
    logic [CNT_BITS-1:0]                 j_reg, j_next;
    logic                                last_reg, last_next;
    cma_pkg::out_item_t                  out_reg;

    logic [CNT_BITS-1:0]                 k;
    logic [CNT_BITS-1:0]                 full;
    logic [CNT_BITS-1:0]                 tgt_k;
    logic [CNT_BITS-1:0]                 target;
    logic [CNT_BITS:0]                   ws_wide;
    logic [CNT_BITS:0]                   win_wide;
    logic [CNT_BITS:0]                   rd_wide;
    logic [ADDR_BITS-1:0]                rd_addr;
    logic                                div_done;
    logic signed [cma_pkg::AVG_BITS-1:0] div_quot;

    // half widths beyond the store act as the largest one
    assign k = (int'(hw_reg) > MAX_HALF_WIDTH) ?
               CNT_BITS'(MAX_HALF_WIDTH) : CNT_BITS'(hw_reg);
    assign full   = {k[CNT_BITS-2:0], 1'b1};
    assign tgt_k  = k + j_reg + 1'b1;
    assign target = (tgt_k < seen_reg) ? tgt_k : seen_reg;

    // oldest sample of the window, counted back from the next write slot
    assign ws_wide  = (CNT_BITS + 1)'(ws_reg);
    assign win_wide = (CNT_BITS + 1)'(win_reg);
    assign rd_wide  = (ws_wide >= win_wide) ? ws_wide - win_wide
                    : ws_wide + (CNT_BITS + 1)'(STORE_SLOTS) - win_wide;
    assign rd_addr  = rd_wide[ADDR_BITS-1:0];

    always_comb
    begin
        hw_next   = hw_reg;
        sum_next  = sum_reg;
        seen_next = seen_reg;
        win_next  = win_reg;
        ws_next   = ws_reg;
        j_next    = j_reg;
        last_next = last_reg;
        if (cfg_we)
        begin
            hw_next   = cfg_wdata;
            sum_next  = '0;
            seen_next = '0;
            win_next  = '0;
            ws_next   = '0;
        end
        else if (cmd.accept)
        begin
            sum_next  = sum_reg + SUM_BITS'(in_data.sample);
            win_next  = ((seen_reg < full) ? seen_reg : full) + 1'b1;
            seen_next = (seen_reg < CNT_BITS'(STORE_SLOTS)) ? seen_reg + 1'b1 : seen_reg;
            ws_next   = (ws_reg == ADDR_BITS'(STORE_SLOTS - 1)) ? '0 : ws_reg + 1'b1;
            j_next    = k;
            last_next = in_data.is_last;
        end
        else if (cmd.remove)
        begin
            sum_next = sum_reg - SUM_BITS'(rdata_reg);
            win_next = win_reg - 1'b1;
        end
        else if (cmd.j_dec)
        begin
            j_next = j_reg - 1'b1;
        end
        else if (cmd.end_item && last_reg)
        begin
            sum_next  = '0;
            seen_next = '0;
            win_next  = '0;
            ws_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg   <= cma_pkg::HALF_WIDTH_BITS'(cma_pkg::HALF_WIDTH_RESET);
            sum_reg  <= '0;
            seen_reg <= '0;
            win_reg  <= '0;
            ws_reg   <= '0;
            j_reg    <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            hw_reg   <= hw_next;
            sum_reg  <= sum_next;
            seen_reg <= seen_next;
            win_reg  <= win_next;
            ws_reg   <= ws_next;
            j_reg    <= j_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            store_mem[ws_reg] <= in_data.sample;
        if (cmd.rd_issue)
            rdata_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.average      <= div_quot;
            out_reg.final_result <= last_reg && (j_reg == '0);
        end
    end

    cma_div #(
        .SUM_BITS (SUM_BITS),
        .CNT_BITS (CNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .sum      (sum_reg),
        .divisor  (win_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign status.c_gt_j      = seen_reg > j_reg;
    assign status.w_gt_target = win_reg > target;
    assign status.j_zero      = j_reg == '0;
    assign status.last        = last_reg;
    assign status.div_done    = div_done;
    assign out_data           = out_reg;

    a_empty_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (seen_reg == '0) |-> (sum_reg == '0 && win_reg == '0))
        else $error("window state left over in an empty sequence");

    a_win_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
        win_reg <= seen_reg)
        else $error("window holds more samples than the sequence has");

    a_win_le_full: assert property (@(posedge clk) disable iff (!rst_n)
        win_reg <= full + 1'b1)
        else $error("window wider than the full span");

endmodule

// ===== hdl/cma_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_ctrl
// Sequencer: takes a sample, then for each due result trims the window,
// runs the divider and hands the result over.
// ----------------------------------------------------------------------------
module cma_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  cma_pkg::cma_status_t status,
    output cma_pkg::cma_cmd_t    cmd
);

    typedef enum logic [4:0] {
        IDLE  = 5'b00001,
        CHECK = 5'b00010,
        READ  = 5'b00100,
        DIV   = 5'b01000,
        OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   finish;

    // only a last sample brings further results, until the centre reaches the newest sample
    assign finish = !status.last || status.j_zero;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = CHECK;
                end
            end
            CHECK:
            begin
                priority if (status.c_gt_j && status.w_gt_target)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = READ;
                end
                else if (status.c_gt_j)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = DIV;
                end
                else if (finish)
                begin
                    cmd.end_item = 1'b1;
                    state_next   = IDLE;
                end
                else
                begin
                    cmd.j_dec = 1'b1;
                end
            end
            READ:
            begin
                cmd.remove = 1'b1;
                state_next = CHECK;
            end
            DIV:
            begin
                if (status.div_done)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = OUT;
                end
            end
            OUT:
            begin
                if (!out_stall)
                begin
                    if (finish)
                    begin
                        cmd.end_item = 1'b1;
                        state_next   = IDLE;
                    end
                    else
                    begin
                        cmd.j_dec  = 1'b1;
                        state_next = CHECK;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall  = state_reg != IDLE;
    assign out_valid = state_reg == OUT;

    a_out_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(status.div_done))
        else $error("result offered without a finished division");

endmodule
